FILE: rtl/plids_pkg.sv
// Package for the positional list block: widths, codes, FSM states and shared structs.
package plids_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = 7;
    localparam int KIND_W       = 3;
    localparam int STATUS_W     = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR   = 3'd0,
        KIND_INSERT  = 3'd1,
        KIND_DELETE  = 3'd2,
        KIND_SEARCH  = 3'd3,
        KIND_DISPLAY = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_INVALID  = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CHK,
        S_INS_WR,
        S_DEL_CHK,
        S_DEL_WR,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DISP_RD,
        S_DISP_EMIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [CNT_W-1:0]  rd_addr;
        logic              wr_en;
        logic [CNT_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        status_t           status;
        logic [CNT_W-1:0]  index;
        logic [DATA_W-1:0] element;
        logic [CNT_W-1:0]  count;
        logic              last;
    } res_t;

endpackage

FILE: rtl/plids_mem.sv
// Element storage: one write port, one read port with registered read data.
module plids_mem #(
    parameter int DEPTH = plids_pkg::CAPACITY_DEF
) (
    input  logic                        aclk,
    input  plids_pkg::mem_req_t         req,
    output logic [plids_pkg::DATA_W-1:0] rd_data
);
    import plids_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        // read data holds when no read is issued
        if (req.rd_en) begin
            rd_data_reg <= mem_reg[req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/plids_seq.sv
// Operation sequencer: walks the list one entry per step for shift, search and display.
module plids_seq #(
    parameter int CAPACITY = plids_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [plids_pkg::KIND_W-1:0]   s_kind,
    input  logic [plids_pkg::CNT_W-1:0]    s_position,
    input  logic [plids_pkg::DATA_W-1:0]   s_value,
    input  logic [plids_pkg::DATA_W-1:0]   s_search_key,
    output logic                           res_valid,
    input  logic                           res_ready,
    output plids_pkg::res_t                res,
    output plids_pkg::mem_req_t            mem_req,
    input  logic [plids_pkg::DATA_W-1:0]   rd_data
);
    import plids_pkg::*;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

    state_t              state_reg, state_next;
    logic [KIND_W-1:0]   kind_reg,  kind_next;
    logic [CNT_W-1:0]    pos_reg,   pos_next;
    logic [DATA_W-1:0]   val_reg,   val_next;
    logic [DATA_W-1:0]   key_reg,   key_next;
    logic [CNT_W-1:0]    len_reg,   len_next;
    logic [CNT_W-1:0]    ptr_reg,   ptr_next;
    status_t             stat_reg,  stat_next;
    logic [CNT_W-1:0]    idx_reg,   idx_next;
    logic                disp_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
        end
        kind_reg <= kind_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        key_reg  <= key_next;
        ptr_reg  <= ptr_next;
        stat_reg <= stat_next;
        idx_reg  <= idx_next;
    end

    assign disp_last = ((ptr_reg + ONE_C) == len_reg);

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        key_next   = key_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        stat_next  = stat_reg;
        idx_next   = idx_reg;
        s_ready    = 1'b0;
        res_valid  = 1'b0;
        mem_req    = '0;
        res.status  = stat_reg;
        res.index   = idx_reg;
        res.element = '0;
        res.count   = len_reg;
        res.last    = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next  = s_kind;
                    pos_next   = s_position;
                    val_next   = s_value;
                    key_next   = s_search_key;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                idx_next   = '0;
                stat_next  = STAT_OK;
                state_next = S_EMIT;
                case (kind_reg)
                    KIND_CLEAR: begin
                        len_next = '0;
                    end
                    KIND_INSERT: begin
                        if (pos_reg > len_reg || len_reg >= CAP_C) begin
                            stat_next = STAT_INVALID;
                        end else begin
                            ptr_next   = len_reg;
                            state_next = S_INS_CHK;
                        end
                    end
                    KIND_DELETE: begin
                        if (pos_reg >= len_reg) begin
                            stat_next = STAT_INVALID;
                        end else begin
                            ptr_next   = pos_reg;
                            state_next = S_DEL_CHK;
                        end
                    end
                    KIND_SEARCH: begin
                        ptr_next   = '0;
                        state_next = S_SRCH_RD;
                    end
                    KIND_DISPLAY: begin
                        if (len_reg == '0) begin
                            stat_next = STAT_EMPTY;
                        end else begin
                            ptr_next   = '0;
                            state_next = S_DISP_RD;
                        end
                    end
                    default: begin
                        stat_next = STAT_INVALID;
                    end
                endcase
            end
            S_INS_CHK: begin
                if (ptr_reg > pos_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg - ONE_C;
                    state_next      = S_INS_WR;
                end else begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pos_reg;
                    mem_req.wr_data = val_reg;
                    len_next        = len_reg + ONE_C;
                    state_next      = S_EMIT;
                end
            end
            S_INS_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ptr_reg;
                mem_req.wr_data = rd_data;
                ptr_next        = ptr_reg - ONE_C;
                state_next      = S_INS_CHK;
            end
            S_DEL_CHK: begin
                if ((ptr_reg + ONE_C) < len_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg + ONE_C;
                    state_next      = S_DEL_WR;
                end else begin
                    len_next   = len_reg - ONE_C;
                    state_next = S_EMIT;
                end
            end
            S_DEL_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ptr_reg;
                mem_req.wr_data = rd_data;
                ptr_next        = ptr_reg + ONE_C;
                state_next      = S_DEL_CHK;
            end
            S_SRCH_RD: begin
                if (ptr_reg < len_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg;
                    state_next      = S_SRCH_CMP;
                end else begin
                    stat_next  = STAT_NOTFOUND;
                    state_next = S_EMIT;
                end
            end
            S_SRCH_CMP: begin
                if (rd_data == key_reg) begin
                    idx_next   = ptr_reg;
                    state_next = S_EMIT;
                end else begin
                    ptr_next   = ptr_reg + ONE_C;
                    state_next = S_SRCH_RD;
                end
            end
            S_DISP_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ptr_reg;
                state_next      = S_DISP_EMIT;
            end
            S_DISP_EMIT: begin
                res_valid   = 1'b1;
                res.status  = STAT_OK;
                res.index   = ptr_reg;
                res.element = rd_data;
                res.last    = disp_last;
                if (res_ready) begin
                    if (disp_last) begin
                        state_next = S_IDLE;
                    end else begin
                        ptr_next   = ptr_reg + ONE_C;
                        state_next = S_DISP_RD;
                    end
                end
            end
            S_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/positional_list_insert_delete_search_top.sv
// Top level of the positional list: sequencer, element memory and result output register.
//
//  channel | dir | handshake          | word fields
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_valid / s_ready  | kind, position, value, search_key
//  m_      | out | m_valid / m_ready  | status, index, element, count, last
//
// Work per word: clear and rejected words touch no entry; insert moves the
// entries from position to the end up; delete moves those after position
// down; search inspects entries until the first match or the end; display
// reads and emits every element. Each entry moved or inspected takes a read
// and then a write or compare over the single memory port pair.
// Reset (aresetn low, synchronous) empties the list; element storage is not
// cleared. s_ready is low from acceptance until the last result word has left
// the sequencer; a stalled m_ready holds results in the output register.
module positional_list_insert_delete_search_top #(
    parameter int CAPACITY = plids_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [plids_pkg::KIND_W-1:0]   s_kind,
    input  logic [plids_pkg::CNT_W-1:0]    s_position,
    input  logic [plids_pkg::DATA_W-1:0]   s_value,
    input  logic [plids_pkg::DATA_W-1:0]   s_search_key,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [plids_pkg::STATUS_W-1:0] m_status,
    output logic [plids_pkg::CNT_W-1:0]    m_index,
    output logic [plids_pkg::DATA_W-1:0]   m_element,
    output logic [plids_pkg::CNT_W-1:0]    m_count,
    output logic                           m_last
);
    import plids_pkg::*;

    mem_req_t          mem_req;
    logic [DATA_W-1:0] rd_data;
    res_t              res;
    logic              res_valid;
    logic              res_ready;

    // output word register
    res_t              out_reg;
    logic              out_valid_reg;

    plids_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_position   (s_position),
        .s_value      (s_value),
        .s_search_key (s_search_key),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_req      (mem_req),
        .rd_data      (rd_data)
    );

    plids_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // register takes a new word when empty or draining this cycle
    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_status  = out_reg.status;
    assign m_index   = out_reg.index;
    assign m_element = out_reg.element;
    assign m_count   = out_reg.count;
    assign m_last    = out_reg.last;

`ifndef SYNTHESIS
    // the list never holds more than its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_count} <= (CNT_W + 1)'(CAPACITY)))
        else $error("count above capacity");

    // an accepted word keeps the input closed for at least the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after accept");

    // empty status only on an empty list
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_EMPTY) |-> (m_count == '0))
        else $error("empty status with elements held");

    // non-final display words lie strictly below the final index
    a_display_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (({1'b0, m_index} + 8'd1) < {1'b0, m_count}))
        else $error("display index out of order");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the positional list block: queued stimulus, predictor, word checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import plids_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;
    // Kinds past display are undefined; the block answers them with an invalid status.
    localparam logic [KIND_W-1:0] KIND_UNDEF_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNDEF_HI = 3'd7;
    // Hard stop, far beyond the slowest legal run (full-list displays under heavy stall).
    localparam int CYCLE_LIMIT = 400_000;
    // Drain time after the last expected word: longer than the slowest single operation.
    localparam int TAIL_CYCLES = 300;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  position;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] search_key;
    } list_op_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind       = '0;
    logic [CNT_W-1:0]    s_position   = '0;
    logic [DATA_W-1:0]   s_value      = '0;
    logic [DATA_W-1:0]   s_search_key = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [CNT_W-1:0]    m_index;
    logic [DATA_W-1:0]   m_element;
    logic [CNT_W-1:0]    m_count;
    logic                m_last;

    // Operations still to be sent, and the list length they will leave behind.
    list_op_t    op_queue[$];
    int unsigned plan_len = 0;

    // Predictor state: its own copy of the list.
    logic [DATA_W-1:0] list_mem [LIST_CAP];
    int unsigned       list_len = 0;
    res_t              predicted_words[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count   = 0;
    int unsigned words_seen    = 0;
    int unsigned cycle_count   = 0;

    positional_list_insert_delete_search_top #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_position  (s_position),
        .s_value     (s_value),
        .s_search_key(s_search_key),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_index     (m_index),
        .m_element   (m_element),
        .m_count     (m_count),
        .m_last      (m_last)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH: %s", msg);
    endtask

    // Value source: a small pool 45% of the time so duplicates and search hits are common.
    function automatic logic [DATA_W-1:0] pick_word();
        if ($urandom_range(0, 99) >= 45)
            return $urandom();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0007;
            4: return 32'h8000_0000;
            default: return 32'h7fff_ffff;
        endcase
    endfunction

    // Queue one operation and track the length it should leave, so that
    // later positions can be aimed at the valid range.
    function automatic void queue_op(input logic [KIND_W-1:0] kind,
                                     input logic [CNT_W-1:0] pos,
                                     input logic [DATA_W-1:0] val,
                                     input logic [DATA_W-1:0] key);
        list_op_t op;
        op.kind       = kind;
        op.position   = pos;
        op.value      = val;
        op.search_key = key;
        op_queue.push_back(op);
        case (kind)
            KIND_CLEAR:  plan_len = 0;
            KIND_INSERT: if (pos <= plan_len && plan_len < LIST_CAP) plan_len++;
            KIND_DELETE: if (pos < plan_len) plan_len--;
            default: ;
        endcase
    endfunction

    // Mostly well-formed traffic: short list builds (clear then appends) and
    // in-range operations, with a share of fully random noise words.
    task automatic plan_random(input int n_ops);
        int start;
        int sel;
        int k;
        start = op_queue.size();
        while (op_queue.size() < start + n_ops) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                queue_op(KIND_CLEAR, CNT_W'($urandom_range(0, 127)), $urandom(), $urandom());
                k = $urandom_range(1, 6);
                repeat (k) queue_op(KIND_INSERT, CNT_W'(plan_len), pick_word(), $urandom());
                queue_op(KIND_DISPLAY, CNT_W'($urandom_range(0, 127)), $urandom(), $urandom());
            end else if (sel < 85) begin
                case ($urandom_range(0, 3))
                    0: queue_op(KIND_INSERT, CNT_W'($urandom_range(0, plan_len)),
                                pick_word(), $urandom());
                    1: queue_op(KIND_DELETE,
                                CNT_W'(plan_len != 0 ? $urandom_range(0, plan_len - 1) : 0),
                                $urandom(), $urandom());
                    2: queue_op(KIND_SEARCH, CNT_W'($urandom_range(0, 127)),
                                $urandom(), pick_word());
                    default: queue_op(KIND_DISPLAY, CNT_W'($urandom_range(0, 127)),
                                      $urandom(), $urandom());
                endcase
            end else begin
                queue_op(KIND_W'($urandom_range(0, 7)), CNT_W'($urandom_range(0, 127)),
                         $urandom(), $urandom());
            end
        end
    endtask

    // Build a full list, hit the full-list case, and shift the whole list both ways.
    task automatic plan_fill();
        queue_op(KIND_CLEAR, 7'd0, '0, '0);
        repeat (LIST_CAP) queue_op(KIND_INSERT, CNT_W'(plan_len), pick_word(), $urandom());
        queue_op(KIND_INSERT, CNT_W'(plan_len), $urandom(), $urandom());
        queue_op(KIND_INSERT, 7'd0, $urandom(), $urandom());
        queue_op(KIND_SEARCH, 7'd0, '0, pick_word());
        queue_op(KIND_DISPLAY, 7'd0, '0, '0);
        queue_op(KIND_DELETE, 7'd0, '0, '0);
        queue_op(KIND_INSERT, 7'd0, pick_word(), '0);
        queue_op(KIND_DELETE, CNT_W'(LIST_CAP - 1), '0, '0);
        queue_op(KIND_DISPLAY, 7'd0, '0, '0);
    endtask

    // Predictor: apply one accepted word to the list copy and queue the
    // result words it must produce.
    task automatic apply_list_op(input list_op_t op);
        res_t r;
        int   i;
        r        = '0;
        r.status = STAT_OK;
        r.last   = 1'b1;
        case (op.kind)
            KIND_CLEAR: begin
                list_len = 0;
            end
            KIND_INSERT: begin
                if (op.position > list_len || list_len >= LIST_CAP) begin
                    r.status = STAT_INVALID;
                end else begin
                    for (i = list_len; i > op.position; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[op.position] = op.value;
                    list_len++;
                end
            end
            KIND_DELETE: begin
                if (op.position >= list_len) begin
                    r.status = STAT_INVALID;
                end else begin
                    for (i = op.position; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            KIND_SEARCH: begin
                // first match wins
                r.status = STAT_NOTFOUND;
                for (i = list_len - 1; i >= 0; i--) begin
                    if (list_mem[i] == op.search_key) begin
                        r.status = STAT_OK;
                        r.index  = CNT_W'(i);
                    end
                end
            end
            KIND_DISPLAY: begin
                if (list_len == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    for (i = 0; i < list_len; i++) begin
                        r.index   = CNT_W'(i);
                        r.element = list_mem[i];
                        r.count   = CNT_W'(list_len);
                        r.last    = (i + 1 == list_len);
                        predicted_words.push_back(r);
                    end
                    return;
                end
            end
            default: begin
                r.status = STAT_INVALID;
            end
        endcase
        r.count = CNT_W'(list_len);
        predicted_words.push_back(r);
    endtask

    // Driver: predict on acceptance, then present the next word or idle.
    always @(posedge aclk) begin
        list_op_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                nxt.kind       = s_kind;
                nxt.position   = s_position;
                nxt.value      = s_value;
                nxt.search_key = s_search_key;
                apply_list_op(nxt);
            end
            // Only move on once the current word is gone; valid holds otherwise.
            if (!s_valid || s_ready) begin
                if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = op_queue.pop_front();
                    s_valid      <= 1'b1;
                    s_kind       <= nxt.kind;
                    s_position   <= nxt.position;
                    s_value      <= nxt.value;
                    s_search_key <= nxt.search_key;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result word against the oldest prediction.
    always @(posedge aclk) begin
        res_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (predicted_words.size() == 0) begin
                    report_mismatch($sformatf("word %0d: no result was due", words_seen));
                end else begin
                    want = predicted_words.pop_front();
                    if (m_status !== want.status)
                        report_mismatch($sformatf("word %0d status: got %0d want %0d",
                                                  words_seen, m_status, want.status));
                    if (m_index !== want.index)
                        report_mismatch($sformatf("word %0d index: got %0d want %0d",
                                                  words_seen, m_index, want.index));
                    if (m_element !== want.element)
                        report_mismatch($sformatf("word %0d element: got %0d want %0d",
                                                  words_seen, $signed(m_element),
                                                  $signed(want.element)));
                    if (m_count !== want.count)
                        report_mismatch($sformatf("word %0d count: got %0d want %0d",
                                                  words_seen, m_count, want.count));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("word %0d last: got %0d want %0d",
                                                  words_seen, m_last, want.last));
                end
                words_seen++;
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("positional_list_insert_delete_search_top test failed");
            $finish;
        end
    end

    initial begin
        int k;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Phase 1: sender idles 32%, receiver 69%. Directed cases first.
        send_idle_pct = 32;
        recv_idle_pct = 69;
        queue_op(KIND_DISPLAY, 7'd0, '0, '0);                    // display of empty list
        queue_op(KIND_SEARCH, 7'd0, '0, 32'h8000_0000);          // search on empty list
        queue_op(KIND_DELETE, 7'd0, '0, '0);                     // delete out of range
        queue_op(KIND_INSERT, 7'd1, 32'h0000_1234, '0);          // insert past the end
        queue_op(KIND_INSERT, 7'd0, 32'h8000_0000, '0);
        queue_op(KIND_INSERT, 7'd1, 32'h7fff_ffff, '0);          // append
        queue_op(KIND_INSERT, 7'd1, 32'h0000_0000, '0);          // middle
        queue_op(KIND_INSERT, 7'd0, 32'hffff_ffff, '0);          // head
        queue_op(KIND_INSERT, 7'd4, 32'd5, '0);
        queue_op(KIND_INSERT, 7'd127, 32'hffff_ffff, 32'hffff_ffff);
        queue_op(KIND_SEARCH, 7'd127, '0, 32'h7fff_ffff);        // hit
        queue_op(KIND_SEARCH, 7'd0, '0, 32'd12345);              // no match
        queue_op(KIND_INSERT, 7'd2, 32'h0000_0000, '0);          // duplicate value
        queue_op(KIND_SEARCH, 7'd0, '0, 32'h0000_0000);          // first of two matches
        queue_op(KIND_DISPLAY, 7'd0, '0, '0);
        queue_op(KIND_DELETE, 7'd0, '0, '0);                     // delete head
        queue_op(KIND_DELETE, 7'd4, '0, '0);                     // delete tail
        queue_op(KIND_DELETE, 7'd127, '0, '0);
        queue_op(KIND_DELETE, 7'd4, '0, '0);                     // position equal to length
        for (k = KIND_UNDEF_LO; k <= KIND_UNDEF_HI; k++)
            queue_op(KIND_W'(k), CNT_W'($urandom_range(0, 127)), $urandom(), $urandom());
        queue_op(KIND_DISPLAY, 7'd0, '0, '0);
        queue_op(KIND_CLEAR, 7'd127, 32'hffff_ffff, 32'hffff_ffff);
        queue_op(KIND_DISPLAY, 7'd0, '0, '0);
        plan_random(10);
        while (op_queue.size() != 0) @(posedge aclk);

        // Phase 2: roles swapped; full list and whole-list shifts.
        send_idle_pct = 69;
        recv_idle_pct = 32;
        plan_fill();
        plan_random(6);
        while (op_queue.size() != 0) @(posedge aclk);

        // Phase 3: no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        plan_random(10);

        // Wait for every word to be accepted and every result to arrive,
        // then give stray words time to show up.
        while (op_queue.size() != 0 || s_valid || predicted_words.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("positional_list_insert_delete_search_top test passed");
        end else begin
            $display("positional_list_insert_delete_search_top test failed");
        end
        $finish;
    end

endmodule
